/* rtl/sddf_pkg.sv */
// Package for the slow DoS flow detector: constants, register indexes, cause codes.
// No dependencies.
`default_nettype none
package sddf_pkg;
    localparam int FLOW_ENTRIES   = 1024;
    localparam int SOURCE_ENTRIES = 1024;
    localparam int FLOW_AW = $clog2(FLOW_ENTRIES);
    localparam int SRC_AW  = $clog2(SOURCE_ENTRIES);
    localparam logic [15:0] TLS_PORT = 16'd443;
    localparam logic [31:0] ACTIVITY_PACKETS  = 32'd5;
    localparam logic [31:0] LORIS_MIN_PACKETS = 32'd2;

    typedef enum logic [2:0] {
        CAUSE_NONE  = 3'd0,
        CAUSE_FLOOD = 3'd1,
        CAUSE_LORIS = 3'd2,
        CAUSE_POST  = 3'd3,
        CAUSE_READ  = 3'd4
    } cause_t;

    localparam logic [2:0] REG_HDR_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_MIN_RATE    = 3'd1;
    localparam logic [2:0] REG_MAX_CONN    = 3'd2;
    localparam logic [2:0] REG_LORIS_CONN  = 3'd3;
    localparam logic [2:0] REG_POST_MIN    = 3'd4;
    localparam logic [2:0] REG_ZW_LIMIT    = 3'd5;
    localparam logic [2:0] REG_PORT_A      = 3'd6;
    localparam logic [2:0] REG_PORT_B      = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_MUL, ST_CMP, ST_OUT
    } state_t;

    typedef struct packed {
        logic [47:0] start_ms;
        logic [31:0] bytes;
        logic        header_done;
        logic        loris_flagged;
        logic        post_flagged;
        logic [15:0] zero_windows;
    } flow_rec_t;
endpackage
`default_nettype wire

/* rtl/slow_dos_flow_detector.sv */
// Top level of the slow DoS flow detector: flow and source memories, sequencer.
// Depends on sddf_pkg.
//
// channel  direction  handshake          payload
// s_axis   in         tvalid/tready      descriptor fields in tdata
// m_axis   out        tvalid/tready      alert, cause in tdata
// cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// After reset a clearing pass over all entries (max of both store depths)
// zeroes the memories; no input is taken meanwhile.
// Each item passes through accept, memory read, rate products (32x48 split into
// two 32x24 multiplies computed together), compare and write back. The verdict
// is loaded into the output register at write back and offered the next cycle.
// Input is taken while a verdict waits; write back holds while the output
// register is still occupied and the sink is not ready.
`default_nettype none
module slow_dos_flow_detector (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // flow_slot[9:0], source_slot[19:10], is_tcp[20], dest_port[36:21],
    // tcp_flags[44:37], payload_bytes[60:45], blank_line_seen[61],
    // window[77:62], flow_packet_count[109:78], now_ms[157:110]
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // alert[0], cause[3:1]
    output logic [7:0]        m_axis_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import sddf_pkg::*;

    localparam int CLR_W = (FLOW_AW > SRC_AW) ? FLOW_AW : SRC_AW;

    logic [15:0] hdr_to_reg, flood_lim_reg, loris_conn_reg, post_min_reg, zw_lim_reg;
    logic [15:0] port_a_reg, port_b_reg;
    logic [31:0] min_rate_reg;

    state_t state_reg, state_next;
    logic [CLR_W:0] clr_reg;
    logic [159:0] in_reg;
    logic [2:0]   cause_reg;
    logic         ovalid_reg;

    flow_rec_t flow_mem [FLOW_ENTRIES];
    logic [15:0] src_mem [SOURCE_ENTRIES];
    flow_rec_t fr_q;
    logic [15:0] sr_q;

    // unpacked fields
    logic [FLOW_AW-1:0] f_a;
    logic [SRC_AW-1:0]  s_a;
    logic        tcp, blank;
    logic [15:0] port, pay, win;
    logic [7:0]  flags;
    logic [31:0] pkts;
    logic [47:0] now;
    assign f_a   = in_reg[FLOW_AW-1:0];
    assign s_a   = in_reg[10 +: SRC_AW];
    assign tcp   = in_reg[20];
    assign port  = in_reg[36:21];
    assign flags = in_reg[44:37];
    assign pay   = in_reg[60:45];
    assign blank = in_reg[61];
    assign win   = in_reg[77:62];
    assign pkts  = in_reg[109:78];
    assign now   = in_reg[157:110];

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_to_reg <= 16'd10; min_rate_reg <= 32'd100; flood_lim_reg <= 16'd100;
            loris_conn_reg <= 16'd10; post_min_reg <= 16'd30; zw_lim_reg <= 16'd5;
            port_a_reg <= 16'd80; port_b_reg <= 16'd8080;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HDR_TIMEOUT: hdr_to_reg     <= cfg_data[15:0];
                REG_MIN_RATE:    min_rate_reg   <= cfg_data;
                REG_MAX_CONN:    flood_lim_reg  <= cfg_data[15:0];
                REG_LORIS_CONN:  loris_conn_reg <= cfg_data[15:0];
                REG_POST_MIN:    post_min_reg   <= cfg_data[15:0];
                REG_ZW_LIMIT:    zw_lim_reg     <= cfg_data[15:0];
                REG_PORT_A:      port_a_reg     <= cfg_data[15:0];
                REG_PORT_B:      port_b_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // decode and derived values from the read record
    logic plain, web, syn_only, finrst, ack;
    logic [47:0] elapsed;
    logic [31:0] bytes_new;
    logic        hdr_new;
    logic [32:0] bsum;
    assign plain    = (port == port_a_reg) || (port == port_b_reg);
    assign web      = plain || (port == TLS_PORT);
    assign syn_only = flags[1] && !flags[4];
    assign finrst   = flags[0] || flags[2];
    assign ack      = flags[4];
    assign elapsed  = (now >= fr_q.start_ms) ? now - fr_q.start_ms : 48'd0;
    assign bsum     = {1'b0, fr_q.bytes} + {17'd0, pay};
    assign bytes_new = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
    assign hdr_new  = fr_q.header_done || (plain && pay != 16'd0 && blank);

    // rate: bytes*1000 < rate*elapsed  (equivalent to floor division form)
    logic [41:0] lhs_reg;
    logic [55:0] ph_reg, pl_reg;      // rate*elapsed[47:24], rate*elapsed[23:0]
    logic [80:0] rhs;
    assign rhs = {1'b0, ph_reg, 24'd0} + {25'd0, pl_reg};
    logic low_rate;
    assign low_rate = (min_rate_reg != 32'd0) && ({39'd0, lhs_reg} < rhs);
    logic [63:0] hto_ms, post_ms;
    assign hto_ms  = {48'd0, hdr_to_reg} * 64'd1000;
    assign post_ms = {48'd0, post_min_reg} * 64'd1000;

    // verdict
    flow_rec_t wr_rec;
    logic [15:0] wr_src;
    logic        wr_f, wr_s;
    logic [2:0]  cause_c;
    logic        loris_hit, post_hit;
    logic [15:0] zw_inc;
    always_comb
    begin
        wr_rec = fr_q; wr_src = sr_q; wr_f = 1'b0; wr_s = 1'b0;
        cause_c = CAUSE_NONE; loris_hit = 1'b0; post_hit = 1'b0;
        zw_inc = (fr_q.zero_windows == 16'hFFFF) ? 16'hFFFF : fr_q.zero_windows + 16'd1;
        if (tcp && web)
        begin
            if (syn_only)
            begin
                wr_f = 1'b1; wr_s = 1'b1;
                wr_rec.start_ms = now; wr_rec.bytes = '0; wr_rec.header_done = 1'b0;
                wr_rec.loris_flagged = 1'b0; wr_rec.post_flagged = 1'b0;
                if (sr_q != 16'hFFFF) wr_src = sr_q + 16'd1;
            end
            else if (finrst)
            begin
                wr_s = 1'b1;
                if (sr_q != 16'd0) wr_src = sr_q - 16'd1;
            end
            else if (fr_q.start_ms != 48'd0)
            begin
                wr_f = 1'b1;
                wr_rec.bytes = bytes_new; wr_rec.header_done = hdr_new;
                if (port == TLS_PORT)
                    loris_hit = bytes_new != 0 && low_rate && pkts > ACTIVITY_PACKETS
                                && sr_q >= loris_conn_reg;
                else
                    loris_hit = !hdr_new && bytes_new != 0 && pkts >= LORIS_MIN_PACKETS;
                loris_hit = loris_hit && !fr_q.loris_flagged
                            && {16'd0, elapsed} >= hto_ms;
                post_hit = !fr_q.post_flagged && plain && hdr_new
                           && {16'd0, elapsed} >= post_ms && bytes_new != 0
                           && ((elapsed != 0) ? low_rate : (min_rate_reg != 0));
                if (sr_q > flood_lim_reg)
                    cause_c = CAUSE_FLOOD;
                else if (loris_hit)
                begin
                    wr_rec.loris_flagged = 1'b1; cause_c = CAUSE_LORIS;
                end
                else if (post_hit)
                begin
                    wr_rec.post_flagged = 1'b1; cause_c = CAUSE_POST;
                end
                else if (ack && pkts > ACTIVITY_PACKETS)
                begin
                    if (win == 16'd0)
                    begin
                        wr_rec.zero_windows = zw_inc;
                        if (zw_inc >= zw_lim_reg) cause_c = CAUSE_READ;
                    end
                    else
                        wr_rec.zero_windows = '0;
                end
            end
        end
    end

    logic clr_done;
    logic out_fire;
    assign clr_done = clr_reg[CLR_W];
    // write back only once the output register is free or being emptied
    assign out_fire = (state_reg == ST_OUT) && (!ovalid_reg || m_axis_tready);
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == {1'b0, {CLR_W{1'b1}}}) state_next = ST_IDLE;
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_CMP;
            ST_CMP:   state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            ovalid_reg <= 1'b0;
            cause_reg <= CAUSE_NONE;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR && !clr_done)
                clr_reg <= clr_reg + {{CLR_W{1'b0}}, 1'b1};
            if (out_fire)
            begin
                ovalid_reg <= 1'b1;
                cause_reg <= cause_c;
            end
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) in_reg <= s_axis_tdata;
        if (state_reg == ST_READ)
        begin
            fr_q <= flow_mem[f_a];
            sr_q <= src_mem[s_a];
        end
        if (state_reg == ST_MUL)
        begin
            lhs_reg <= {10'd0, bytes_new} * 42'd1000;
            ph_reg  <= {24'd0, min_rate_reg} * {32'd0, elapsed[47:24]};
            pl_reg  <= {24'd0, min_rate_reg} * {32'd0, elapsed[23:0]};
        end
        if (state_reg == ST_CLEAR)
        begin
            flow_mem[clr_reg[FLOW_AW-1:0]] <= '0;
            src_mem[clr_reg[SRC_AW-1:0]]   <= '0;
        end
        else if (out_fire)
        begin
            if (wr_f) flow_mem[f_a] <= wr_rec;
            if (wr_s) src_mem[s_a]  <= wr_src;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {4'd0, cause_reg, cause_reg != CAUSE_NONE};
endmodule
`default_nettype wire
